### sv/config_text_lexer_defines.svh
// ----------------------------------------------------------------------------
// config_text_lexer_defines
// Assertion macros for the lexer RTL.
// ----------------------------------------------------------------------------
`ifndef CONFIG_TEXT_LEXER_DEFINES_SVH
`define CONFIG_TEXT_LEXER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CTLEX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CTLEX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ctlex_pkg.sv
// ----------------------------------------------------------------------------
// ctlex_pkg
// Types and constants shared by the configuration text lexer.
// ----------------------------------------------------------------------------
package ctlex_pkg;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [0:0] REG_KEEP_WS  = 1'b0;
    localparam logic [0:0] REG_KEEP_CMT = 1'b1;

    typedef enum logic [2:0] {
        KIND_SPACE   = 3'd0,
        KIND_COMMENT = 3'd1,
        KIND_SQUOTE  = 3'd2,
        KIND_DQUOTE  = 3'd3,
        KIND_COLON   = 3'd4,
        KIND_IDENT   = 3'd5,
        KIND_UNKNOWN = 3'd6,
        KIND_END     = 3'd7
    } t_kind;

    typedef struct packed {
        logic space;
        logic newline;
        logic hash;
        logic squote;
        logic dquote;
        logic colon;
        logic word;
    } t_char_class;

    typedef struct packed {
        logic keep_ws;
        logic keep_cmt;
    } t_keep;

    typedef struct packed {
        logic       pres;
        logic       eos;
        logic [1:0] slot;
        logic       commit;
    } t_step_ctl;

endpackage

### sv/config_text_lexer.sv
// ----------------------------------------------------------------------------
// config_text_lexer
// Streaming tokenizer for configuration text: one source byte per item in,
// one token per item out.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle into an input register while the block is
// ready for them; the token step for the held byte is combinational and its
// tokens go out through a single output register, one token per cycle while
// the sink is ready. A byte that yields more than one token (at most three: a
// closed token, a single-byte token or flushed token, and the end token)
// holds the input while the output register drains them. There is no
// start-up pass after reset.
`include "config_text_lexer_defines.svh"

module config_text_lexer #(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // config write port
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [0:0] i_cfg_data,
    // source bytes
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_code
    input  logic       i_s_axis_tuser,   // [0] char_present
    input  logic       i_s_axis_tlast,   // end_of_source
    // tokens
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    // data_offset, data_size, token_width, start_line, start_column, zero pad
    output logic [((3*POSITION_BITS+2*LENGTH_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    output logic [2:0] o_m_axis_tuser,   // [2:0] token_kind
    output logic       o_m_axis_tlast    // final_token
);
    import ctlex_pkg::*;

    localparam int PB      = POSITION_BITS;
    localparam int LB      = LENGTH_BITS;
    localparam int TDATA_W = ((3*PB+2*LB+7)/8)*8;

    t_keep       r_keep;
    logic        r_in_vld;
    logic [7:0]  r_code;
    logic        r_pres;
    logic        r_eos;
    logic [1:0]  r_slot;

    t_char_class w_cls;
    t_step_ctl   w_ctl;
    logic [1:0]  w_cnt;
    t_kind       w_kind;
    logic [PB-1:0] w_off, w_line, w_col;
    logic [LB-1:0] w_size, w_wid;
    logic        w_fin;
    logic        w_out_free;
    logic        w_load;
    logic        w_done;
    logic [TDATA_W-1:0] w_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep.keep_ws  <= 1'b1;
            r_keep.keep_cmt <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEEP_WS:  r_keep.keep_ws  <= i_cfg_data[0];
                REG_KEEP_CMT: r_keep.keep_cmt <= i_cfg_data[0];
                default:      r_keep <= r_keep;
            endcase
        end
    end

    assign w_load = r_in_vld && (w_cnt != 2'd0) && w_out_free;
    assign w_done = r_in_vld &&
                    ((w_cnt == 2'd0) || (w_out_free && (r_slot == w_cnt - 2'd1)));
    assign o_s_axis_tready = !r_in_vld || w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_slot   <= 2'd0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (w_done) begin
                r_slot <= 2'd0;
            end else if (w_load) begin
                r_slot <= r_slot + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_code <= i_s_axis_tdata;
            r_pres <= i_s_axis_tuser;
            r_eos  <= i_s_axis_tlast;
        end
    end

    ctlex_class u_class (
        .i_code (r_code),
        .o_cls  (w_cls)
    );

    assign w_ctl.pres   = r_pres;
    assign w_ctl.eos    = r_eos;
    assign w_ctl.slot   = r_slot;
    assign w_ctl.commit = w_done;

    ctlex_core #(
        .POSITION_BITS (PB),
        .LENGTH_BITS   (LB)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cls   (w_cls),
        .i_keep  (r_keep),
        .i_ctl   (w_ctl),
        .o_cnt   (w_cnt),
        .o_kind  (w_kind),
        .o_off   (w_off),
        .o_size  (w_size),
        .o_wid   (w_wid),
        .o_line  (w_line),
        .o_col   (w_col),
        .o_fin   (w_fin)
    );

    assign w_tdata = TDATA_W'({w_col, w_line, w_wid, w_size, w_off});

    ctlex_obuf #(
        .DATA_W (TDATA_W)
    ) u_obuf (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_load),
        .i_data          (w_tdata),
        .i_kind          (w_kind),
        .i_fin           (w_fin),
        .o_free          (w_out_free),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    `CTLEX_ASSERT_IMP(a_slot_in_range, r_in_vld && (w_cnt != 2'd0), r_slot < w_cnt, "token slot past count")
    `CTLEX_ASSERT_IMP(a_end_always, r_in_vld && r_eos, w_cnt != 2'd0, "end of source without end token")
    `CTLEX_ASSERT_NXT(a_slot_cleared, w_done, r_slot == 2'd0, "slot not cleared after item")
    `CTLEX_ASSERT_NXT(a_item_held, w_load && !w_done, r_in_vld, "item dropped with tokens pending")
    `CTLEX_ASSERT_IMP(a_last_is_end, o_m_axis_tvalid, o_m_axis_tlast == (o_m_axis_tuser == KIND_END), "tlast and end kind disagree")

endmodule

### sv/ctlex_class.sv
// ----------------------------------------------------------------------------
// ctlex_class
// Byte classifier: whitespace, word characters and delimiters.
// ----------------------------------------------------------------------------
module ctlex_class (
    input  logic [7:0]            i_code,
    output ctlex_pkg::t_char_class o_cls
);
    import ctlex_pkg::*;

    always_comb begin
        o_cls.newline = (i_code == CH_NL);
        o_cls.space   = (i_code == CH_SPACE) || (i_code == CH_TAB) ||
                        (i_code == CH_CR) || (i_code == CH_NL);
        o_cls.hash    = (i_code == CH_HASH);
        o_cls.squote  = (i_code == CH_SQUOTE);
        o_cls.dquote  = (i_code == CH_DQUOTE);
        o_cls.colon   = (i_code == CH_COLON);
        o_cls.word    = (i_code >= 8'h61 && i_code <= 8'h7A) ||
                        (i_code >= 8'h41 && i_code <= 8'h5A) ||
                        (i_code >= 8'h30 && i_code <= 8'h39) ||
                        (i_code == CH_UNDER);
    end

endmodule

### sv/ctlex_core.sv
// ----------------------------------------------------------------------------
// ctlex_core
// Lexer state and token step: works out up to three tokens for the held item
// and presents the one picked by the slot index; state advances on commit.
// ----------------------------------------------------------------------------
module ctlex_core #(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ctlex_pkg::t_char_class   i_cls,
    input  ctlex_pkg::t_keep         i_keep,
    input  ctlex_pkg::t_step_ctl     i_ctl,
    output logic [1:0]               o_cnt,
    output ctlex_pkg::t_kind         o_kind,
    output logic [POSITION_BITS-1:0] o_off,
    output logic [LENGTH_BITS-1:0]   o_size,
    output logic [LENGTH_BITS-1:0]   o_wid,
    output logic [POSITION_BITS-1:0] o_line,
    output logic [POSITION_BITS-1:0] o_col,
    output logic                     o_fin
);
    import ctlex_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam int LB = LENGTH_BITS;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_SPACE   = 3'd1,
        M_COMMENT = 3'd2,
        M_SQUOTE  = 3'd3,
        M_DQUOTE  = 3'd4,
        M_WORD    = 3'd5
    } t_mode;

    typedef struct packed {
        t_kind          kind;
        logic [PB-1:0]  off;
        logic [LB-1:0]  size;
        logic [LB-1:0]  wid;
        logic [PB-1:0]  line;
        logic [PB-1:0]  col;
        logic           fin;
    } t_res;

    function automatic logic [PB-1:0] pos_inc(input logic [PB-1:0] a);
        return (&a) ? a : a + 1'b1;
    endfunction

    function automatic logic [LB-1:0] len_add(input logic [LB-1:0] a,
                                              input logic [1:0] d);
        logic [LB:0] s;
        s = {1'b0, a} + {{(LB-1){1'b0}}, d};
        return s[LB] ? {LB{1'b1}} : s[LB-1:0];
    endfunction

    t_mode         r_mode, n_mode;
    logic [PB-1:0] r_open_off, n_open_off;
    logic [LB-1:0] r_open_len, n_open_len;
    logic [PB-1:0] r_open_line, n_open_line;
    logic [PB-1:0] r_open_col, n_open_col;
    logic [PB-1:0] r_line, n_line;
    logic [PB-1:0] r_col, n_col;
    logic [PB-1:0] r_boff, n_boff;

    t_mode         mode1;
    logic [PB-1:0] off1, line1, col1, cline1, ccol1, boff1;
    logic [LB-1:0] len1;
    logic          done;
    logic [3:0]    emit;
    t_res          cand [4];
    t_res          sel;
    logic [1:0]    seen;
    logic [1:0]    c1_delim;
    logic [LB-1:0] all_len;

    always_comb begin
        mode1    = r_mode;
        off1     = r_open_off;
        len1     = r_open_len;
        line1    = r_open_line;
        col1     = r_open_col;
        cline1   = r_line;
        ccol1    = r_col;
        boff1    = r_boff;
        done     = 1'b0;
        emit     = 4'b0000;
        c1_delim = 2'd0;

        cand[0]      = '0;
        cand[0].line = r_open_line;
        cand[0].col  = r_open_col;
        cand[0].size = r_open_len;
        cand[0].off  = r_open_off;

        cand[1]      = '0;
        cand[1].kind = i_cls.colon ? KIND_COLON : KIND_UNKNOWN;
        cand[1].off  = r_boff;
        cand[1].size = {{(LB-1){1'b0}}, 1'b1};
        cand[1].wid  = {{(LB-1){1'b0}}, 1'b1};
        cand[1].line = r_line;
        cand[1].col  = r_col;

        // byte step
        if (i_ctl.pres) begin
            unique case (r_mode)
                M_SPACE: begin
                    if (i_cls.space) begin
                        len1 = len_add(r_open_len, 2'd1);
                        done = 1'b1;
                    end else begin
                        emit[0]      = i_keep.keep_ws;
                        cand[0].kind = KIND_SPACE;
                        mode1        = M_IDLE;
                    end
                end
                M_COMMENT: begin
                    if (!i_cls.newline) begin
                        len1 = len_add(r_open_len, 2'd1);
                        done = 1'b1;
                    end else begin
                        emit[0]      = i_keep.keep_cmt;
                        cand[0].kind = KIND_COMMENT;
                        cand[0].off  = pos_inc(r_open_off);
                        c1_delim     = 2'd1;
                        mode1        = M_IDLE;
                    end
                end
                M_SQUOTE, M_DQUOTE: begin
                    done = 1'b1;
                    if ((r_mode == M_SQUOTE) ? i_cls.squote : i_cls.dquote) begin
                        emit[0]      = 1'b1;
                        cand[0].kind = (r_mode == M_SQUOTE) ? KIND_SQUOTE : KIND_DQUOTE;
                        cand[0].off  = pos_inc(r_open_off);
                        c1_delim     = 2'd2;
                        mode1        = M_IDLE;
                    end else begin
                        len1 = len_add(r_open_len, 2'd1);
                    end
                end
                M_WORD: begin
                    if (i_cls.word) begin
                        len1 = len_add(r_open_len, 2'd1);
                        done = 1'b1;
                    end else begin
                        emit[0]      = 1'b1;
                        cand[0].kind = KIND_IDENT;
                        mode1        = M_IDLE;
                    end
                end
                default: mode1 = M_IDLE;
            endcase

            if (!done) begin
                priority if (i_cls.space) begin
                    mode1 = M_SPACE;
                    len1  = {{(LB-1){1'b0}}, 1'b1};
                end else if (i_cls.hash) begin
                    mode1 = M_COMMENT;
                    len1  = '0;
                end else if (i_cls.squote) begin
                    mode1 = M_SQUOTE;
                    len1  = '0;
                end else if (i_cls.dquote) begin
                    mode1 = M_DQUOTE;
                    len1  = '0;
                end else if (i_cls.word) begin
                    mode1 = M_WORD;
                    len1  = {{(LB-1){1'b0}}, 1'b1};
                end else begin
                    emit[1] = 1'b1;
                end
                if (!emit[1]) begin
                    off1  = r_boff;
                    line1 = r_line;
                    col1  = r_col;
                end
            end

            boff1 = pos_inc(r_boff);
            if (i_cls.newline) begin
                cline1 = pos_inc(r_line);
                ccol1  = {{(PB-1){1'b0}}, 1'b1};
            end else begin
                ccol1  = pos_inc(r_col);
            end
        end
        cand[0].wid = len_add(r_open_len, c1_delim);

        // end of source: flush open token, then end token
        all_len      = len_add(len1, 2'd1);
        cand[2]      = '0;
        cand[2].off  = off1;
        cand[2].size = len1;
        cand[2].wid  = len1;
        cand[2].line = line1;
        cand[2].col  = col1;
        cand[3]      = '0;
        cand[3].kind = KIND_END;
        cand[3].fin  = 1'b1;
        if (i_ctl.eos) begin
            emit[3] = 1'b1;
            unique case (mode1)
                M_SPACE: begin
                    emit[2]      = i_keep.keep_ws;
                    cand[2].kind = KIND_SPACE;
                end
                M_COMMENT: begin
                    emit[2]      = i_keep.keep_cmt;
                    cand[2].kind = KIND_COMMENT;
                    cand[2].off  = pos_inc(off1);
                    cand[2].wid  = all_len;
                end
                M_SQUOTE, M_DQUOTE: begin
                    emit[2]      = 1'b1;
                    cand[2].kind = KIND_UNKNOWN;
                    cand[2].size = all_len;
                    cand[2].wid  = all_len;
                end
                M_WORD: begin
                    emit[2]      = 1'b1;
                    cand[2].kind = KIND_IDENT;
                end
                default: emit[2] = 1'b0;
            endcase
        end

        sel  = cand[3];
        seen = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (emit[i]) begin
                if (seen == i_ctl.slot) begin
                    sel = cand[i];
                end
                seen = seen + 2'd1;
            end
        end
    end

    assign o_cnt  = {1'b0, emit[0]} + {1'b0, emit[1]} + {1'b0, emit[2]} + {1'b0, emit[3]};
    assign o_kind = sel.kind;
    assign o_off  = sel.off;
    assign o_size = sel.size;
    assign o_wid  = sel.wid;
    assign o_line = sel.line;
    assign o_col  = sel.col;
    assign o_fin  = sel.fin;

    always_comb begin
        if (i_ctl.eos) begin
            n_mode      = M_IDLE;
            n_open_off  = '0;
            n_open_len  = '0;
            n_open_line = {{(PB-1){1'b0}}, 1'b1};
            n_open_col  = {{(PB-1){1'b0}}, 1'b1};
            n_line      = {{(PB-1){1'b0}}, 1'b1};
            n_col       = {{(PB-1){1'b0}}, 1'b1};
            n_boff      = '0;
        end else begin
            n_mode      = mode1;
            n_open_off  = off1;
            n_open_len  = len1;
            n_open_line = line1;
            n_open_col  = col1;
            n_line      = cline1;
            n_col       = ccol1;
            n_boff      = boff1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_open_off  <= '0;
            r_open_len  <= '0;
            r_open_line <= {{(PB-1){1'b0}}, 1'b1};
            r_open_col  <= {{(PB-1){1'b0}}, 1'b1};
            r_line      <= {{(PB-1){1'b0}}, 1'b1};
            r_col       <= {{(PB-1){1'b0}}, 1'b1};
            r_boff      <= '0;
        end else if (i_ctl.commit) begin
            r_mode      <= n_mode;
            r_open_off  <= n_open_off;
            r_open_len  <= n_open_len;
            r_open_line <= n_open_line;
            r_open_col  <= n_open_col;
            r_line      <= n_line;
            r_col       <= n_col;
            r_boff      <= n_boff;
        end
    end

endmodule

### sv/ctlex_obuf.sv
// ----------------------------------------------------------------------------
// ctlex_obuf
// Token output register on the master stream side.
// ----------------------------------------------------------------------------
module ctlex_obuf #(
    parameter int DATA_W = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [DATA_W-1:0] i_data,
    input  ctlex_pkg::t_kind  i_kind,
    input  logic              i_fin,
    output logic              o_free,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [DATA_W-1:0] o_m_axis_tdata,
    output logic [2:0]        o_m_axis_tuser,
    output logic              o_m_axis_tlast
);
    import ctlex_pkg::*;

    logic              r_vld;
    logic [DATA_W-1:0] r_data;
    t_kind             r_kind;
    logic              r_fin;

    assign o_free = !r_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_data;
            r_kind <= i_kind;
            r_fin  <= i_fin;
        end
    end

    assign o_m_axis_tvalid = r_vld;
    assign o_m_axis_tdata  = r_data;
    assign o_m_axis_tuser  = r_kind;
    assign o_m_axis_tlast  = r_fin;

endmodule

### verif/config_text_lexer_checker.sv
// ----------------------------------------------------------------------------
// config_text_lexer_checker
// Watches the config port and both streams of the lexer, tokenizes every
// accepted source item on its own, and compares each token that leaves the
// block, field by field, with the oldest token it predicted.
// ----------------------------------------------------------------------------
module config_text_lexer_checker #(
    parameter int TDATA_W = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [0:0]         i_cfg_data,
    input  logic               i_src_valid,
    input  logic               i_src_ready,
    input  logic [7:0]         i_src_data,
    input  logic               i_src_user,
    input  logic               i_src_last,
    input  logic               i_tok_valid,
    input  logic               i_tok_ready,
    input  logic [TDATA_W-1:0] i_tok_data,
    input  logic [2:0]         i_tok_user,
    input  logic               i_tok_last,
    output int                 o_fail_count,
    output int                 o_tokens_due,
    output int                 o_tokens_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import ctlex_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_SPACE,
        MODE_COMMENT,
        MODE_SQUOTE,
        MODE_DQUOTE,
        MODE_WORD
    } t_lex_mode;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] offset;
        logic [15:0] size;
        logic [15:0] width;
        logic [31:0] line;
        logic [31:0] column;
        logic        final_tok;
    } t_token;

    t_lex_mode   mode;
    logic [31:0] tok_offset;
    logic [15:0] tok_len;
    logic [31:0] tok_line;
    logic [31:0] tok_column;
    logic [31:0] cur_line;
    logic [31:0] cur_column;
    logic [31:0] src_offset;
    logic        keep_ws;
    logic        keep_cmt;
    t_token      tokens_due[$];

    function automatic logic [31:0] pos_inc(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic logic [15:0] len_add(input logic [15:0] a, input logic [1:0] b);
        logic [16:0] s;
        s = {1'b0, a} + 17'(b);
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NL;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == CH_UNDER;
    endfunction

    function automatic void emit_token(input t_kind k, input logic [31:0] off,
                                       input logic [15:0] size, input logic [15:0] width,
                                       input logic [31:0] line, input logic [31:0] col,
                                       input logic fin);
        t_token t;
        t.kind      = k;
        t.offset    = off;
        t.size      = size;
        t.width     = width;
        t.line      = line;
        t.column    = col;
        t.final_tok = fin;
        tokens_due.push_back(t);
    endfunction

    function automatic void close_open(input t_kind k, input logic [1:0] delims,
                                       input logic [31:0] data_off);
        emit_token(k, data_off, tok_len, len_add(tok_len, delims), tok_line, tok_column, 1'b0);
        mode = MODE_IDLE;
    endfunction

    function automatic void open_tok(input t_lex_mode m, input logic [15:0] len);
        mode       = m;
        tok_offset = src_offset;
        tok_len    = len;
        tok_line   = cur_line;
        tok_column = cur_column;
    endfunction

    function automatic void clear_position();
        mode       = MODE_IDLE;
        tok_offset = '0;
        tok_len    = '0;
        tok_line   = 32'd1;
        tok_column = 32'd1;
        cur_line   = 32'd1;
        cur_column = 32'd1;
        src_offset = '0;
    endfunction

    function automatic void lex_byte(input logic [7:0] c);
        logic        taken;
        logic [31:0] inner;
        taken = 1'b0;
        inner = pos_inc(tok_offset);
        case (mode)
            MODE_SPACE: begin
                if (is_blank(c)) begin
                    tok_len = len_add(tok_len, 2'd1);
                    taken   = 1'b1;
                end else if (keep_ws) begin
                    close_open(KIND_SPACE, 2'd0, tok_offset);
                end else begin
                    mode = MODE_IDLE;
                end
            end
            MODE_COMMENT: begin
                if (c != CH_NL) begin
                    tok_len = len_add(tok_len, 2'd1);
                    taken   = 1'b1;
                end else if (keep_cmt) begin
                    close_open(KIND_COMMENT, 2'd1, inner);
                end else begin
                    mode = MODE_IDLE;
                end
            end
            MODE_SQUOTE, MODE_DQUOTE: begin
                taken = 1'b1;
                if (c == (mode == MODE_SQUOTE ? CH_SQUOTE : CH_DQUOTE)) begin
                    close_open(mode == MODE_SQUOTE ? KIND_SQUOTE : KIND_DQUOTE, 2'd2, inner);
                end else begin
                    tok_len = len_add(tok_len, 2'd1);
                end
            end
            MODE_WORD: begin
                if (is_word(c)) begin
                    tok_len = len_add(tok_len, 2'd1);
                    taken   = 1'b1;
                end else begin
                    close_open(KIND_IDENT, 2'd0, tok_offset);
                end
            end
            default: mode = MODE_IDLE;
        endcase

        if (!taken) begin
            if (is_blank(c)) begin
                open_tok(MODE_SPACE, 16'd1);
            end else if (c == CH_HASH) begin
                open_tok(MODE_COMMENT, 16'd0);
            end else if (c == CH_SQUOTE) begin
                open_tok(MODE_SQUOTE, 16'd0);
            end else if (c == CH_DQUOTE) begin
                open_tok(MODE_DQUOTE, 16'd0);
            end else if (is_word(c)) begin
                open_tok(MODE_WORD, 16'd1);
            end else begin
                emit_token(c == CH_COLON ? KIND_COLON : KIND_UNKNOWN, src_offset, 16'd1,
                           16'd1, cur_line, cur_column, 1'b0);
            end
        end

        src_offset = pos_inc(src_offset);
        if (c == CH_NL) begin
            cur_line   = pos_inc(cur_line);
            cur_column = 32'd1;
        end else begin
            cur_column = pos_inc(cur_column);
        end
    endfunction

    function automatic void lex_end();
        logic [15:0] all;
        case (mode)
            MODE_SPACE: if (keep_ws) close_open(KIND_SPACE, 2'd0, tok_offset);
            MODE_COMMENT: if (keep_cmt) close_open(KIND_COMMENT, 2'd1, pos_inc(tok_offset));
            MODE_SQUOTE, MODE_DQUOTE: begin
                // open quote at end of source: one unknown token from the quote on
                all = len_add(tok_len, 2'd1);
                emit_token(KIND_UNKNOWN, tok_offset, all, all, tok_line, tok_column, 1'b0);
            end
            MODE_WORD: close_open(KIND_IDENT, 2'd0, tok_offset);
            default: ;
        endcase
        emit_token(KIND_END, '0, '0, '0, '0, '0, 1'b1);
        clear_position();
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            o_fail_count++;
            $display("%0t: token %0d %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, o_tokens_checked, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_token want;
        if (!i_rst_n) begin
            keep_ws  = 1'b1;
            keep_cmt = 1'b1;
            clear_position();
            tokens_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_KEEP_WS) begin
                    keep_ws = i_cfg_data[0];
                end else if (i_cfg_idx == REG_KEEP_CMT) begin
                    keep_cmt = i_cfg_data[0];
                end
            end
            if (i_src_valid && i_src_ready) begin
                if (i_src_user) lex_byte(i_src_data);
                if (i_src_last) lex_end();
            end
            if (i_tok_valid && i_tok_ready) begin
                if (tokens_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: token mismatch: expected none, actual kind %0d data 0x%0h last %0b",
                             $time, i_tok_user, i_tok_data, i_tok_last);
                end else begin
                    want = tokens_due.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_tok_user));
                    check_field("data_offset", want.offset, i_tok_data[31:0]);
                    check_field("data_size", 32'(want.size), 32'(i_tok_data[47:32]));
                    check_field("token_width", 32'(want.width), 32'(i_tok_data[63:48]));
                    check_field("start_line", want.line, i_tok_data[95:64]);
                    check_field("start_column", want.column, i_tok_data[127:96]);
                    check_field("final_token", 32'(want.final_tok), 32'(i_tok_last));
                    o_tokens_checked++;
                end
            end
        end
        o_tokens_due = tokens_due.size();
    end

endmodule

### verif/tb_config_text_lexer.sv
// ----------------------------------------------------------------------------
// tb_config_text_lexer
// Drives source bytes into the lexer in bursts, with a stalling token sink,
// through a directed source and random sources under all four keep settings.
// The checker beside the block predicts and compares every token; this
// module gives the verdict.
// ----------------------------------------------------------------------------
module tb_config_text_lexer;
    timeunit 1ns;
    timeprecision 1ps;
    import ctlex_pkg::*;

    localparam int TDATA_W     = ((3*32 + 2*16 + 7)/8)*8;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 26;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [0:0]         i_cfg_idx;
    logic [0:0]         i_cfg_data;
    logic               i_s_axis_tvalid;
    logic               o_s_axis_tready;
    logic [7:0]         i_s_axis_tdata;
    logic               i_s_axis_tuser;
    logic               i_s_axis_tlast;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready;
    logic [TDATA_W-1:0] o_m_axis_tdata;
    logic [2:0]         o_m_axis_tuser;
    logic               o_m_axis_tlast;

    int   fail_count;
    int   tokens_due;
    int   tokens_checked;
    int   gap_max;
    int   burst_left;
    int   stall_pct;
    int   stall_left;
    int   n_items;
    int   quiet_cycles;
    logic ready_nxt;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    config_text_lexer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    config_text_lexer_checker #(
        .TDATA_W (TDATA_W)
    ) u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_src_valid      (i_s_axis_tvalid),
        .i_src_ready      (o_s_axis_tready),
        .i_src_data       (i_s_axis_tdata),
        .i_src_user       (i_s_axis_tuser),
        .i_src_last       (i_s_axis_tlast),
        .i_tok_valid      (o_m_axis_tvalid),
        .i_tok_ready      (i_m_axis_tready),
        .i_tok_data       (o_m_axis_tdata),
        .i_tok_user       (o_m_axis_tuser),
        .i_tok_last       (o_m_axis_tlast),
        .o_fail_count     (fail_count),
        .o_tokens_due     (tokens_due),
        .o_tokens_checked (tokens_checked)
    );

    // token sink: random stalls of random length, rate set per phase
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            ready_nxt = 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(7);
            ready_nxt  = 1'b0;
        end else begin
            ready_nxt = 1'b1;
        end
        i_m_axis_tready <= ready_nxt;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d tokens still due",
                     $time, quiet_cycles, tokens_due);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic put_item(input logic [7:0] code, input logic pres, input logic eos);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(gap_max);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(16, 1);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= code;
        i_s_axis_tuser  <= pres;
        i_s_axis_tlast  <= eos;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        n_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) put_item(s[i], 1'b1, 1'b0);
    endtask

    task automatic drain_tokens();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (tokens_due != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // close the current source, let the block go idle, then change settings
    task automatic begin_phase(input logic ws, input logic cmt, input int stall,
                               input int gap);
        put_item(8'($urandom_range(255)), 1'b0, 1'b1);
        drain_tokens();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_KEEP_WS;
        i_cfg_data <= ws;
        @(negedge i_clk);
        i_cfg_idx  <= REG_KEEP_CMT;
        i_cfg_data <= cmt;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        stall_pct  = stall;
        gap_max    = gap;
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            default: return CH_NL;
        endcase
    endfunction

    function automatic logic [7:0] pick_word_char();
        int r;
        r = $urandom_range(62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return CH_UNDER;
    endfunction

    // mostly well-formed tokens with random content, some noise and open quotes
    task automatic random_token();
        logic [7:0] c;
        logic [7:0] q;
        case ($urandom_range(11))
            0, 1: repeat ($urandom_range(6, 1)) put_item(pick_word_char(), 1'b1, 1'b0);
            2: repeat ($urandom_range(4, 1)) put_item(pick_blank(), 1'b1, 1'b0);
            3: begin
                put_item(CH_HASH, 1'b1, 1'b0);
                repeat ($urandom_range(6)) begin
                    c = 8'($urandom_range(255));
                    if (c == CH_NL) c = CH_HASH;
                    put_item(c, 1'b1, 1'b0);
                end
                if ($urandom_range(4) != 0) put_item(CH_NL, 1'b1, 1'b0);
            end
            4, 5: begin
                q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
                put_item(q, 1'b1, 1'b0);
                repeat ($urandom_range(6)) begin
                    c = 8'($urandom_range(255));
                    if (c == q) c = c ^ 8'h01;
                    put_item(c, 1'b1, 1'b0);
                end
                if ($urandom_range(7) != 0) put_item(q, 1'b1, 1'b0);
            end
            6: put_item(CH_COLON, 1'b1, 1'b0);
            7: put_item(8'($urandom_range(255)), 1'b1, 1'b0);
            8: put_item(8'($urandom_range(255)), 1'b0, 1'b0);
            9: put_item(CH_SPACE, 1'b1, 1'b0);
            10: put_item(8'($urandom_range(255)), 1'b1, 1'b1);
            default: put_item(8'($urandom_range(255)), 1'b0, 1'b1);
        endcase
    endtask

    task automatic random_source(input int count);
        int stop;
        stop = n_items + count;
        while (n_items < stop) random_token();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_KEEP_WS;
        i_cfg_data      = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        i_s_axis_tuser  = 1'b0;
        i_s_axis_tlast  = 1'b0;
        i_m_axis_tready = 1'b0;
        gap_max         = 4;
        stall_pct       = 30;
        burst_left      = 0;
        n_items         = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed source under the reset settings
        send_text("a_9 \t");
        put_item(CH_CR, 1'b1, 1'b0);
        put_item(CH_HASH, 1'b1, 1'b0);
        put_item(8'h00, 1'b1, 1'b0);          // zero byte inside a comment
        send_text("\nx:'\"");
        put_item(8'h00, 1'b1, 1'b0);          // zero byte inside a quote
        send_text("'\"'\"");
        put_item(8'hFF, 1'b1, 1'b0);
        put_item(8'h80, 1'b1, 1'b0);
        put_item(8'h00, 1'b1, 1'b0);
        put_item(8'hFF, 1'b0, 1'b0);          // bare item, ignored
        send_text("\"a");
        put_item("b", 1'b1, 1'b1);            // unterminated quote at end
        send_text("9z");
        put_item(CH_COLON, 1'b1, 1'b1);       // word, colon and end at once
        put_item(8'h00, 1'b0, 1'b1);          // empty source
        put_item(CH_HASH, 1'b1, 1'b1);

        begin_phase(1'b0, 1'b0, 30, 4);
        random_source(PHASE_ITEMS);
        begin_phase(1'b1, 1'b0, 60, 8);
        random_source(PHASE_ITEMS / 2);
        drain_tokens();
        random_source(PHASE_ITEMS / 2);
        begin_phase(1'b0, 1'b1, 0, 0);
        random_source(PHASE_ITEMS);
        begin_phase(1'b1, 1'b1, 20, 2);
        random_source(PHASE_ITEMS);
        put_item(8'h00, 1'b0, 1'b1);

        i_s_axis_tvalid <= 1'b0;
        while (tokens_due != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("Sent %0d source items, checked %0d tokens", n_items, tokens_checked);
        $display("All four keep_whitespace/keep_comments settings, with and without stalls");
        if (fail_count == 0 && tokens_due == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### config_text_lexer.f
+incdir+sv
sv/ctlex_pkg.sv
sv/ctlex_class.sv
sv/ctlex_core.sv
sv/ctlex_obuf.sv
sv/config_text_lexer.sv
verif/config_text_lexer_checker.sv
verif/tb_config_text_lexer.sv
